// ----- sv/lstmc_pkg.sv -----
// Package for the Q15 LSTM cell: operation codes, controller command type,
// the tanh table and the saturation and tanh helpers. No dependencies.
`default_nettype none
package lstmc_pkg;

    localparam int NUM_UNITS_DEF = 16;
    localparam int WADDR_W       = 11;
    localparam int WDEPTH        = 2048;
    localparam int BADDR_W       = 6;
    localparam int BDEPTH        = 64;
    localparam int ACC_W         = 24;

    localparam logic [1:0] OP_WEIGHT = 2'd0;
    localparam logic [1:0] OP_BIAS   = 2'd1;
    localparam logic [1:0] OP_STATE  = 2'd2;
    localparam logic [1:0] OP_INPUT  = 2'd3;

    localparam logic [1:0] GATE_FORGET = 2'd0;
    localparam logic [1:0] GATE_CAND   = 2'd1;
    localparam logic [1:0] GATE_INPUT  = 2'd2;
    localparam logic [1:0] GATE_OUTPUT = 2'd3;

    localparam logic signed [15:0] SIG_OFFSET = 16'sd16384;
    localparam logic signed [15:0] TANH_MAX   = 16'sh7fe9;
    localparam logic [14:0]        TANH_LAST  = 15'd255;

    typedef enum logic [3:0] {
        ST_IDLE, ST_BIAS, ST_MAC, ST_ACT, ST_CELL1, ST_CELL2,
        ST_TANHC, ST_HID, ST_OUT, ST_COMMIT
    } state_t;

    typedef struct packed {
        logic       in_wr;
        logic       bias_rd;
        logic       mac_issue;
        logic       acc_load;
        logic       act_en;
        logic       cell1;
        logic       cell2;
        logic       tanhc;
        logic       hid;
        logic       commit;
        logic [1:0] gate;
        logic [3:0] unit;
        logic [3:0] col;
        logic       msel;
    } cmd_t;

    localparam logic [15:0] TANH_TBL [256] = '{
        16'h0000, 16'h0200, 16'h0400, 16'h05ff, 16'h07fd, 16'h09fb, 16'h0bf7, 16'h0df2,
        16'h0feb, 16'h11e2, 16'h13d7, 16'h15c9, 16'h17b9, 16'h19a6, 16'h1b90, 16'h1d76,
        16'h1f59, 16'h2139, 16'h2314, 16'h24ec, 16'h26bf, 16'h288e, 16'h2a58, 16'h2c1e,
        16'h2ddf, 16'h2f9a, 16'h3151, 16'h3302, 16'h34ae, 16'h3655, 16'h37f6, 16'h3991,
        16'h3b27, 16'h3cb6, 16'h3e40, 16'h3fc4, 16'h4142, 16'h42ba, 16'h442c, 16'h4598,
        16'h46fd, 16'h485d, 16'h49b6, 16'h4b09, 16'h4c56, 16'h4d9d, 16'h4edd, 16'h5018,
        16'h514d, 16'h527b, 16'h53a3, 16'h54c6, 16'h55e2, 16'h56f9, 16'h580a, 16'h5914,
        16'h5a1a, 16'h5b19, 16'h5c13, 16'h5d07, 16'h5df6, 16'h5edf, 16'h5fc4, 16'h60a2,
        16'h617c, 16'h6250, 16'h6320, 16'h63ea, 16'h64b0, 16'h6571, 16'h662d, 16'h66e4,
        16'h6797, 16'h6846, 16'h68f0, 16'h6995, 16'h6a37, 16'h6ad4, 16'h6b6e, 16'h6c03,
        16'h6c95, 16'h6d22, 16'h6dac, 16'h6e33, 16'h6eb5, 16'h6f35, 16'h6fb0, 16'h7029,
        16'h709e, 16'h7110, 16'h717f, 16'h71eb, 16'h7254, 16'h72ba, 16'h731e, 16'h737e,
        16'h73dc, 16'h7437, 16'h7490, 16'h74e6, 16'h753a, 16'h758b, 16'h75da, 16'h7627,
        16'h7672, 16'h76ba, 16'h7701, 16'h7745, 16'h7788, 16'h77c8, 16'h7807, 16'h7844,
        16'h787f, 16'h78b8, 16'h78f0, 16'h7926, 16'h795b, 16'h798e, 16'h79bf, 16'h79ef,
        16'h7a1e, 16'h7a4b, 16'h7a77, 16'h7aa2, 16'h7acb, 16'h7af4, 16'h7b1b, 16'h7b41,
        16'h7b65, 16'h7b89, 16'h7bab, 16'h7bcd, 16'h7bee, 16'h7c0d, 16'h7c2c, 16'h7c49,
        16'h7c66, 16'h7c82, 16'h7c9d, 16'h7cb8, 16'h7cd1, 16'h7cea, 16'h7d02, 16'h7d19,
        16'h7d30, 16'h7d46, 16'h7d5b, 16'h7d70, 16'h7d84, 16'h7d97, 16'h7daa, 16'h7dbc,
        16'h7dce, 16'h7ddf, 16'h7df0, 16'h7e00, 16'h7e0f, 16'h7e1f, 16'h7e2d, 16'h7e3c,
        16'h7e49, 16'h7e57, 16'h7e64, 16'h7e70, 16'h7e7d, 16'h7e88, 16'h7e94, 16'h7e9f,
        16'h7eaa, 16'h7eb4, 16'h7ebf, 16'h7ec8, 16'h7ed2, 16'h7edb, 16'h7ee4, 16'h7eed,
        16'h7ef5, 16'h7efd, 16'h7f05, 16'h7f0d, 16'h7f14, 16'h7f1c, 16'h7f23, 16'h7f29,
        16'h7f30, 16'h7f36, 16'h7f3d, 16'h7f43, 16'h7f48, 16'h7f4e, 16'h7f54, 16'h7f59,
        16'h7f5e, 16'h7f63, 16'h7f68, 16'h7f6c, 16'h7f71, 16'h7f75, 16'h7f7a, 16'h7f7e,
        16'h7f82, 16'h7f86, 16'h7f89, 16'h7f8d, 16'h7f91, 16'h7f94, 16'h7f97, 16'h7f9b,
        16'h7f9e, 16'h7fa1, 16'h7fa4, 16'h7fa6, 16'h7fa9, 16'h7fac, 16'h7fae, 16'h7fb1,
        16'h7fb3, 16'h7fb6, 16'h7fb8, 16'h7fba, 16'h7fbc, 16'h7fbe, 16'h7fc0, 16'h7fc2,
        16'h7fc4, 16'h7fc6, 16'h7fc8, 16'h7fca, 16'h7fcb, 16'h7fcd, 16'h7fce, 16'h7fd0,
        16'h7fd1, 16'h7fd3, 16'h7fd4, 16'h7fd6, 16'h7fd7, 16'h7fd8, 16'h7fd9, 16'h7fdb,
        16'h7fdc, 16'h7fdd, 16'h7fde, 16'h7fdf, 16'h7fe0, 16'h7fe1, 16'h7fe2, 16'h7fe3,
        16'h7fe4, 16'h7fe5, 16'h7fe5, 16'h7fe6, 16'h7fe7, 16'h7fe8, 16'h7fe9, 16'h7fe9
    };

    function automatic logic signed [15:0] sat16(input logic signed [ACC_W-1:0] v);
        logic signed [15:0] r;
        if (v > ACC_W'(32767)) begin
            r = 16'sh7fff;
        end else if (v < -ACC_W'(32768)) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    // Odd-symmetric table tanh with linear interpolation between points
    // 512 apart; y0*(512-f)+y1*f is rewritten as y0*512+(y1-y0)*f.
    function automatic logic signed [15:0] tanh_q15(input logic signed [ACC_W-1:0] x);
        logic              neg;
        logic [ACC_W-1:0]  mag;
        logic [7:0]        idx;
        logic signed [16:0] y0;
        logic signed [16:0] d;
        logic signed [26:0] prod;
        logic signed [16:0] y;
        neg  = x[ACC_W-1];
        mag  = neg ? ACC_W'(-x) : ACC_W'(x);
        idx  = mag[16:9];
        y0   = 17'(signed'({1'b0, TANH_TBL[idx]}));
        d    = 17'(signed'({1'b0, TANH_TBL[8'(idx + 8'd1)]})) - y0;
        prod = 27'(d) * 27'(signed'({1'b0, mag[8:0]}));
        if (mag[ACC_W-1:9] >= (ACC_W-9)'(TANH_LAST)) begin
            y = 17'(TANH_MAX);
        end else begin
            y = y0 + 17'(prod >>> 9);
        end
        return neg ? 16'(-y) : y[15:0];
    endfunction

endpackage
`default_nettype wire

// ----- sv/lstmc_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none
module lstmc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule
`default_nettype wire

// ----- sv/lstmc_datapath.sv -----
// Datapath of the LSTM cell: weight and bias memories, state registers, the
// shared multiply-accumulate unit, activations and the cell update.
// Depends on lstmc_pkg and lstmc_ram.
`default_nettype none
module lstmc_datapath #(
    parameter int NUM_UNITS = lstmc_pkg::NUM_UNITS_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire lstmc_pkg::cmd_t    cmd,
    input  wire logic [1:0]         s_op,
    input  wire logic [1:0]         s_gate,
    input  wire logic               s_matrix_sel,
    input  wire logic [3:0]         s_row,
    input  wire logic [3:0]         s_col,
    input  wire logic signed [15:0] s_value,
    input  wire logic signed [15:0] s_second_value,
    output logic signed [15:0]      m_cell_value,
    output logic signed [15:0]      m_hidden_value
);
    import lstmc_pkg::*;

    localparam int UIW = (NUM_UNITS > 1) ? $clog2(NUM_UNITS) : 1;

    logic row_ok, col_ok;
    logic w_we, b_we;
    logic [WADDR_W-1:0] w_waddr, w_raddr;
    logic [BADDR_W-1:0] b_waddr, b_raddr;
    logic signed [15:0] w_rd, b_rd;

    logic signed [15:0] cell_reg   [NUM_UNITS];
    logic signed [15:0] hid_reg    [NUM_UNITS];
    logic signed [15:0] newh_reg   [NUM_UNITS];
    logic signed [15:0] invec_reg  [NUM_UNITS];
    logic signed [15:0] gval_reg   [4];

    logic signed [15:0]      x_reg;
    logic                    iss_v_reg, mul_v_reg;
    logic signed [31:0]      prod_reg;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic signed [ACC_W-1:0] act_in;
    logic signed [15:0]      act_t;
    logic signed [31:0]      p1_reg;
    logic signed [31:0]      ig;
    logic signed [32:0]      csum;
    logic signed [15:0]      c_reg, th_reg, h_reg;
    logic signed [31:0]      hprod;

    function automatic logic signed [15:0] hprod_sat(input logic signed [31:0] p);
        return sat16(ACC_W'(p >>> 15));
    endfunction

    assign row_ok  = 32'(s_row) < NUM_UNITS;
    assign col_ok  = 32'(s_col) < NUM_UNITS;
    assign w_we    = cmd.in_wr && s_op == OP_WEIGHT && row_ok && col_ok;
    assign b_we    = cmd.in_wr && s_op == OP_BIAS && row_ok;
    assign w_waddr = {s_gate, s_matrix_sel, s_row, s_col};
    assign w_raddr = {cmd.gate, cmd.msel, cmd.unit, cmd.col};
    assign b_waddr = {s_gate, s_row};
    assign b_raddr = {cmd.gate, cmd.unit};

    lstmc_ram #(.WIDTH(16), .DEPTH(WDEPTH)) u_wram (
        .aclk(aclk), .wr_en(w_we), .wr_addr(w_waddr), .wr_data(s_value),
        .rd_addr(w_raddr), .rd_data(w_rd)
    );

    lstmc_ram #(.WIDTH(16), .DEPTH(BDEPTH)) u_bram (
        .aclk(aclk), .wr_en(b_we), .wr_addr(b_waddr), .wr_data(s_value),
        .rd_addr(b_raddr), .rd_data(b_rd)
    );

    // Cell and hidden state, with the new hidden values held until the step ends.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_UNITS; i++) begin
                cell_reg[i] <= '0;
                hid_reg[i]  <= '0;
            end
        end else if (cmd.in_wr && s_op == OP_STATE && row_ok) begin
            cell_reg[s_row[UIW-1:0]] <= s_value;
            hid_reg[s_row[UIW-1:0]]  <= s_second_value;
        end else if (cmd.hid) begin
            cell_reg[cmd.unit[UIW-1:0]] <= c_reg;
        end else if (cmd.commit) begin
            for (int i = 0; i < NUM_UNITS; i++) begin
                hid_reg[i] <= newh_reg[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.in_wr && s_op == OP_INPUT && col_ok) begin
            invec_reg[s_col[UIW-1:0]] <= s_value;
        end
        if (cmd.hid) begin
            newh_reg[cmd.unit[UIW-1:0]] <= hprod_sat(hprod);
        end
    end

    // Multiply-accumulate pipeline: operand fetch, product, accumulate.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            iss_v_reg <= 1'b0;
            mul_v_reg <= 1'b0;
        end else begin
            iss_v_reg <= cmd.mac_issue;
            mul_v_reg <= iss_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg    <= cmd.msel ? hid_reg[cmd.col[UIW-1:0]] : invec_reg[cmd.col[UIW-1:0]];
        prod_reg <= w_rd * x_reg;
        acc_reg  <= acc_next;
    end

    always_comb begin
        acc_next = acc_reg;
        if (cmd.acc_load) begin
            acc_next = ACC_W'(signed'(b_rd));
        end else if (mul_v_reg) begin
            acc_next = acc_reg + ACC_W'(prod_reg >>> 15);
        end
    end

    // The tanh unit serves the gate activations and the tanh of the new cell.
    always_comb begin
        if (cmd.tanhc) begin
            act_in = ACC_W'(c_reg);
        end else if (cmd.gate == GATE_CAND) begin
            act_in = acc_reg;
        end else begin
            act_in = acc_reg >>> 1;
        end
        act_t = tanh_q15(act_in);
        ig    = gval_reg[GATE_INPUT] * gval_reg[GATE_CAND];
        csum  = 33'(p1_reg) + 33'(ig);
        hprod = gval_reg[GATE_OUTPUT] * th_reg;
    end

    always_ff @(posedge aclk) begin
        if (cmd.act_en) begin
            gval_reg[cmd.gate] <= (cmd.gate == GATE_CAND) ? act_t
                                                           : (act_t >>> 1) + SIG_OFFSET;
        end
        if (cmd.cell1) begin
            p1_reg <= gval_reg[GATE_FORGET] * cell_reg[cmd.unit[UIW-1:0]];
        end
        if (cmd.cell2) begin
            c_reg <= sat16(ACC_W'(csum >>> 15));
        end
        if (cmd.tanhc) begin
            th_reg <= act_t;
        end
        if (cmd.hid) begin
            h_reg <= hprod_sat(hprod);
        end
    end

    assign m_cell_value   = c_reg;
    assign m_hidden_value = h_reg;
endmodule
`default_nettype wire

// ----- sv/lstmc_ctrl.sv -----
// Controller of the LSTM cell: sequences gates, products and units of a time
// step and drives the handshakes. Depends on lstmc_pkg.
`default_nettype none
module lstmc_ctrl #(
    parameter int NUM_UNITS = lstmc_pkg::NUM_UNITS_DEF
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    input  wire logic [1:0]      s_op,
    input  wire logic            s_last,
    output logic                 s_ready,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output logic [3:0]           m_unit_index,
    output logic                 m_final_res,
    output lstmc_pkg::cmd_t      cmd
);
    import lstmc_pkg::*;

    localparam int MCW = $clog2(2 * NUM_UNITS + 2);
    localparam logic [MCW-1:0] MAC_ISSUES = MCW'(2 * NUM_UNITS);
    localparam logic [MCW-1:0] MAC_END    = MCW'(2 * NUM_UNITS + 1);
    localparam logic [3:0]     LAST_UNIT  = 4'(NUM_UNITS - 1);

    state_t         state_reg, state_next;
    logic [1:0]     gate_reg, gate_next;
    logic [3:0]     unit_reg, unit_next;
    logic [MCW-1:0] mac_reg, mac_next;
    logic [MCW-1:0] col_full;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            gate_reg  <= '0;
            unit_reg  <= '0;
            mac_reg   <= '0;
        end else begin
            state_reg <= state_next;
            gate_reg  <= gate_next;
            unit_reg  <= unit_next;
            mac_reg   <= mac_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        gate_next  = gate_reg;
        unit_next  = unit_reg;
        mac_next   = mac_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_op == OP_INPUT && s_last) begin
                    state_next = ST_BIAS;
                    gate_next  = '0;
                    unit_next  = '0;
                end
            end
            ST_BIAS: begin
                state_next = ST_MAC;
                mac_next   = '0;
            end
            ST_MAC: begin
                mac_next = mac_reg + 1'b1;
                if (mac_reg == MAC_END) begin
                    state_next = ST_ACT;
                end
            end
            ST_ACT: begin
                if (gate_reg == GATE_OUTPUT) begin
                    state_next = ST_CELL1;
                end else begin
                    gate_next  = gate_reg + 1'b1;
                    state_next = ST_BIAS;
                end
            end
            ST_CELL1: state_next = ST_CELL2;
            ST_CELL2: state_next = ST_TANHC;
            ST_TANHC: state_next = ST_HID;
            ST_HID:   state_next = ST_OUT;
            ST_OUT: begin
                if (m_ready) begin
                    if (unit_reg == LAST_UNIT) begin
                        state_next = ST_COMMIT;
                    end else begin
                        unit_next  = unit_reg + 1'b1;
                        gate_next  = '0;
                        state_next = ST_BIAS;
                    end
                end
            end
            ST_COMMIT: state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // The first half of the products uses W and the input vector, the second U and h.
    assign col_full = (mac_reg < MCW'(NUM_UNITS)) ? mac_reg : mac_reg - MCW'(NUM_UNITS);

    always_comb begin
        cmd           = '0;
        cmd.gate      = gate_reg;
        cmd.unit      = unit_reg;
        cmd.col       = col_full[3:0];
        cmd.msel      = mac_reg >= MCW'(NUM_UNITS);
        cmd.in_wr     = state_reg == ST_IDLE && s_valid;
        cmd.bias_rd   = state_reg == ST_BIAS;
        cmd.mac_issue = state_reg == ST_MAC && mac_reg < MAC_ISSUES;
        cmd.acc_load  = state_reg == ST_MAC && mac_reg == '0;
        cmd.act_en    = state_reg == ST_ACT;
        cmd.cell1     = state_reg == ST_CELL1;
        cmd.cell2     = state_reg == ST_CELL2;
        cmd.tanhc     = state_reg == ST_TANHC;
        cmd.hid       = state_reg == ST_HID;
        cmd.commit    = state_reg == ST_COMMIT;
        s_ready       = state_reg == ST_IDLE;
        m_valid       = state_reg == ST_OUT;
        m_unit_index  = unit_reg;
        m_final_res   = unit_reg == LAST_UNIT;
    end
endmodule
`default_nettype wire

// ----- sv/lstm_cell_fixed_point.sv -----
// Top level of the Q15 LSTM cell: controller and datapath.
// Depends on lstmc_pkg, lstmc_ctrl, lstmc_datapath and lstmc_ram.
//
// Input words load weights (op 0), biases (op 1), initial cell and hidden
// state (op 2) and input-vector elements (op 3). A write word is accepted
// whenever s_ready is high. An input element with s_last set runs one time
// step, and the block then emits one result word per unit in ascending unit
// order, m_final_res marking the last.
// Each gate of each unit runs on the one shared multiply-accumulate unit
// (bias read, products, pipeline drain and activation); the cell and hidden
// update follows before the unit's word is offered, and a whole step ends
// with a commit state that takes over the new hidden values.
// s_ready stays low for the whole step. When the receiver stalls, the
// result word is held unchanged and the step waits.
// Reset clears cell and hidden state to zero and returns to idle; weights,
// biases and input elements are held in storage that reset does not clear.
`default_nettype none
module lstm_cell_fixed_point #(
    parameter int NUM_UNITS = lstmc_pkg::NUM_UNITS_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [1:0]         s_op,
    input  wire logic [1:0]         s_gate,
    input  wire logic               s_matrix_sel,
    input  wire logic [3:0]         s_row,
    input  wire logic [3:0]         s_col,
    input  wire logic signed [15:0] s_value,
    input  wire logic signed [15:0] s_second_value,
    input  wire logic               s_last,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [3:0]              m_unit_index,
    output logic signed [15:0]      m_cell_value,
    output logic signed [15:0]      m_hidden_value,
    output logic                    m_final_res
);
    import lstmc_pkg::*;

    cmd_t cmd;

    lstmc_ctrl #(.NUM_UNITS(NUM_UNITS)) u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_op(s_op),
        .s_last(s_last), .s_ready(s_ready), .m_valid(m_valid), .m_ready(m_ready),
        .m_unit_index(m_unit_index), .m_final_res(m_final_res), .cmd(cmd)
    );

    lstmc_datapath #(.NUM_UNITS(NUM_UNITS)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .s_op(s_op), .s_gate(s_gate),
        .s_matrix_sel(s_matrix_sel), .s_row(s_row), .s_col(s_col),
        .s_value(s_value), .s_second_value(s_second_value),
        .m_cell_value(m_cell_value), .m_hidden_value(m_hidden_value)
    );
endmodule
`default_nettype wire

// ----- sv/lstmc_checker.sv -----
// Port-level checks of the LSTM cell and their binding to the top level.
// Depends on lstmc_pkg and lstm_cell_fixed_point.
`default_nettype none
module lstmc_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic [1:0]  s_op,
    input wire logic        s_last,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [3:0]  m_unit_index,
    input wire logic [15:0] m_cell_value,
    input wire logic [15:0] m_hidden_value,
    input wire logic        m_final_res
);
    import lstmc_pkg::*;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_unit_index)
            && $stable(m_cell_value) && $stable(m_hidden_value) && $stable(m_final_res))
        else $error("result word changed while stalled");

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input taken while a result word is offered");

    a_step_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_op == OP_INPUT && s_last |=> !s_ready && !m_valid)
        else $error("time step did not start after the last element");

    a_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_final_res |=> !m_valid && !s_ready)
        else $error("step ended before the final unit");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result offered straight after reset");
endmodule

bind lstm_cell_fixed_point lstmc_checker u_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .s_op(s_op), .s_last(s_last), .m_valid(m_valid), .m_ready(m_ready),
    .m_unit_index(m_unit_index), .m_cell_value(m_cell_value),
    .m_hidden_value(m_hidden_value), .m_final_res(m_final_res)
);
`default_nettype wire
